FILE: hdl/spk_pkg.sv
// Shared types, constants and rotate helpers for the Speck 32/64 cipher.
`timescale 1ns / 1ps

package spk_pkg;

	localparam int unsigned ROUND_COUNT = 22;
	localparam int unsigned ROUND_W     = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int unsigned WORD_W      = 16;
	localparam int unsigned KEY_WORDS   = 4;
	localparam int unsigned KEY_IDX_W   = $clog2(KEY_WORDS);

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef struct packed {
		logic  operation;
		word_t block_low;
		word_t block_high;
	} spk_in_t;

	typedef struct packed {
		word_t result_low;
		word_t result_high;
	} spk_out_t;

	// One pipeline slot: valid bit, operation and the two halves of the block.
	typedef struct packed {
		logic  valid;
		op_t   op;
		word_t x;
		word_t y;
	} spk_stage_t;

	function automatic word_t ror7(input word_t v);
		return {v[6:0], v[WORD_W-1:7]};
	endfunction

	function automatic word_t rol7(input word_t v);
		return {v[WORD_W-8:0], v[WORD_W-1:WORD_W-7]};
	endfunction

	function automatic word_t ror2(input word_t v);
		return {v[1:0], v[WORD_W-1:2]};
	endfunction

	function automatic word_t rol2(input word_t v);
		return {v[WORD_W-3:0], v[WORD_W-1:WORD_W-2]};
	endfunction

endpackage

FILE: hdl/spk_key_sched.sv
// Key word registers and the serial round-key expander.
`timescale 1ns / 1ps

module spk_key_sched
	import spk_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [KEY_IDX_W-1:0] cfg_index,
	input  word_t                cfg_data,
	output logic                 busy,
	output word_t                round_key [ROUND_COUNT]
);

	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_COUNT - 1);

	word_t              key_q [KEY_WORDS];
	logic               pend_q;
	logic               run_q;
	logic [ROUND_W-1:0] r_q;
	word_t              a_q;
	word_t              mix_q [3];
	word_t              rk_q [ROUND_COUNT];
	word_t              b_next;
	word_t              a_next;

	// One schedule step: mix the head word into the running key.
	assign b_next = word_t'(ror7(mix_q[0]) + a_q) ^ word_t'(r_q);
	assign a_next = rol2(a_q) ^ b_next;

	assign busy      = pend_q | run_q;
	assign round_key = rk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
			pend_q <= 1'b1;
			run_q  <= 1'b0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
			pend_q           <= 1'b1;
			run_q            <= 1'b0;
		end else if (pend_q) begin
			pend_q <= 1'b0;
			run_q  <= 1'b1;
		end else if (run_q && (r_q == LAST_ROUND)) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			a_q      <= key_q[0];
			mix_q[0] <= key_q[1];
			mix_q[1] <= key_q[2];
			mix_q[2] <= key_q[3];
			r_q      <= '0;
		end else if (run_q) begin
			rk_q[r_q] <= a_q;
			a_q       <= a_next;
			mix_q[0]  <= mix_q[1];
			mix_q[1]  <= mix_q[2];
			mix_q[2]  <= b_next;
			r_q       <= r_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("key write did not restart expansion");

	a_pend_run_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && run_q))
		else $error("expander loading and running at once");
`endif

endmodule

FILE: hdl/spk_round.sv
// One registered Speck round, forward or inverse per item.
`timescale 1ns / 1ps

module spk_round
	import spk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  spk_stage_t stage_in,
	input  word_t      rk_enc,
	input  word_t      rk_dec,
	output spk_stage_t stage_out
);

	logic  valid_s1;
	op_t   op_s1;
	word_t x_s1;
	word_t y_s1;
	word_t x_enc;
	word_t y_enc;
	word_t x_dec;
	word_t y_dec;

	always_comb begin
		x_enc = word_t'(ror7(stage_in.x) + stage_in.y) ^ rk_enc;
		y_enc = rol2(stage_in.y) ^ x_enc;
		y_dec = ror2(stage_in.y ^ stage_in.x);
		x_dec = rol7(word_t'((stage_in.x ^ rk_dec) - y_dec));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stage_in.valid;
		end
	end

	// Hold the payload when the slot is empty.
	always_ff @(posedge clk) begin
		if (stage_in.valid) begin
			op_s1 <= stage_in.op;
			if (stage_in.op == OP_DECRYPT) begin
				x_s1 <= x_dec;
				y_s1 <= y_dec;
			end else begin
				x_s1 <= x_enc;
				y_s1 <= y_enc;
			end
		end
	end

	assign stage_out = '{valid: valid_s1, op: op_s1, x: x_s1, y: y_s1};

endmodule

FILE: hdl/speck32_64_block_cipher_top.sv
// Top level of the pipelined Speck 32/64 encrypt/decrypt engine.
`timescale 1ns / 1ps

//  Channel   Signals                       Handshake
//  --------  ----------------------------  ------------------------------------
//  command   cmd (operation, block words)  taken on start && !busy
//  result    result (low and high words)   done strobe, one cycle, no back-off
//  key       cfg_we, cfg_index, cfg_data   written on cfg_we, index 0..3
//
//  One item is taken per cycle while busy is low; each passes through the round
//  pipeline, one register stage per round, and its result shows on done.
//  The result side cannot stall, so the pipeline never holds.
//  After reset, and after every key write, the round keys are expanded one per
//  cycle: busy stays high until the last round key is stored, and no item is taken then.
//  Reset clears the key words to zero and the pipeline valid bits.

module speck32_64_block_cipher_top
	import spk_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  spk_in_t              cmd,
	output logic                 done,
	output spk_out_t             result,
	input  logic                 cfg_we,
	input  logic [KEY_IDX_W-1:0] cfg_index,
	input  word_t                cfg_data
);

	word_t      round_key [ROUND_COUNT];
	spk_stage_t stage [ROUND_COUNT + 1];
	logic       accept;

	// Expand the key schedule into a bank of round-key registers.
	spk_key_sched u_key_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.round_key (round_key)
	);

	assign accept = start & ~busy;

	// Feed the first round straight from the command port.
	always_comb begin
		stage[0].valid = accept;
		stage[0].op    = op_t'(cmd.operation);
		stage[0].x     = cmd.block_high;
		stage[0].y     = cmd.block_low;
	end

	// Chain the rounds; decryption reads the key bank back to front.
	for (genvar j = 0; j < ROUND_COUNT; j++) begin : g_round
		spk_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (stage[j]),
			.rk_enc    (round_key[j]),
			.rk_dec    (round_key[ROUND_COUNT - 1 - j]),
			.stage_out (stage[j + 1])
		);
	end

	// Drive the result straight off the last round register.
	assign done               = stage[ROUND_COUNT].valid;
	assign result.result_low  = stage[ROUND_COUNT].y;
	assign result.result_high = stage[ROUND_COUNT].x;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##ROUND_COUNT done)
		else $error("accepted item did not complete on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, ROUND_COUNT))
		else $error("result without a matching item");
`endif

endmodule
